FILE: sv/swfp_pkg.sv
// Shared types, constants and control/status bundles of the scale weight frame parser.
`default_nettype none

package swfp_pkg;

   localparam int BUFFER_DEPTH       = 32;
   localparam int FIXED_POINT_COLUMN = 10;

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int DEC_W = 3;

   localparam logic [DEC_W-1:0] DEC_LIMIT = DEC_W'(4);
   localparam logic [IDX_W-1:0] POINT_IDX = IDX_W'(FIXED_POINT_COLUMN);
   localparam logic [CNT_W-1:0] POINT_CNT = CNT_W'(FIXED_POINT_COLUMN);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_SCALE_ENABLE = '0;

   localparam logic [7:0] CH_SOH    = 8'h01;
   localparam logic [7:0] CH_STX    = 8'h02;
   localparam logic [7:0] CH_ETX    = 8'h03;
   localparam logic [7:0] CH_EOT    = 8'h04;
   localparam logic [7:0] CH_ACK    = 8'h06;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_F      = 8'h46;
   localparam logic [7:0] CH_STATUS = 8'h53;

   typedef enum logic [1:0] {
      FT_STX = 2'd0,
      FT_F   = 2'd1,
      FT_SOH = 2'd2
   } frame_type_type;

   typedef enum logic [1:0] {
      RK_WEIGHT  = 2'd0,
      RK_XON     = 2'd1,
      RK_ERROR   = 2'd2,
      RK_ENQUIRY = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INSERT,
      ST_CHECK,
      ST_WALK_PRIME,
      ST_WALK_RUN,
      ST_WALK_FLUSH,
      ST_SEND_ENQ,
      ST_SEND_XON,
      ST_SEND_ERR
   } state_type;

   typedef struct packed {
      logic skip;
      logic is_req;
      logic bc_zero;
      logic bc_gt1;
      logic first_ack;
      logic first_start;
      logic type_soh;
      logic is_eot;
      logic soh_ok;
      logic insert;
      logic over_or_lf;
      logic is_cr;
      logic cr_ok;
      logic span_empty;
      logic out_free;
      logic need_push;
      logic walk_end;
      logic pend_valid;
   } status_type;

   typedef struct packed {
      logic     load_item;
      logic     host_clear;
      logic     first_byte;
      logic     xor_eot;
      logic     xor_byte;
      logic     store_byte;
      logic     insert_point;
      logic     clear_count;
      logic     walk_init;
      logic     walk_prime;
      logic     walk_adv;
      logic     push_single;
      logic     push_final;
      kind_type kind;
   } cmd_type;

endpackage

`default_nettype wire

FILE: sv/swfp_if.sv
// Request and result channel interfaces of the scale weight frame parser.
`default_nettype none

interface swfp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   logic       host_error_active;

   modport source (output valid, action, rx_byte, host_error_active, input ready);
   modport sink   (input valid, action, rx_byte, host_error_active, output ready);
endinterface

interface swfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] out_char;
   logic       last_of_run;

   modport source (output valid, result_kind, out_char, last_of_run, input ready);
   modport sink   (input valid, result_kind, out_char, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/swfp_dpath.sv
// Datapath: frame registers, frame store, weight walk and result register.
`default_nettype none

module swfp_dpath import swfp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       scale_enable,
   input  wire logic       in_action,
   input  wire logic [7:0] in_rx_byte,
   input  wire logic       in_host_error_active,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic       out_ready,
   output logic            out_valid,
   output kind_type        out_kind,
   output logic [7:0]      out_char,
   output logic            out_last
);

   logic                 action_ff;
   logic                 herr_ff;
   logic [7:0]           byte_ff;

   logic [CNT_W-1:0]     bc_ff, bc_in;
   logic [IDX_W-1:0]     ds_ff, ds_in;
   logic [IDX_W-1:0]     de_ff, de_in;
   logic [7:0]           xor_ff, xor_in;
   frame_type_type       type_ff, type_in;

   logic [7:0]           mem [BUFFER_DEPTH];
   logic [7:0]           rdata_ff;
   logic [7:0]           hdr_ff [3];
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [7:0]           wr_data;
   logic [IDX_W-1:0]     rd_addr;

   logic [CNT_W-1:0]     p_ff, p_in;
   logic [7:0]           cur_ff, cur_in;
   logic                 ok_ff, ok_in;
   logic [DEC_W-1:0]     dec_ff, dec_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [7:0]           pend_ff, pend_in;

   logic                 ov_ff, ov_in;
   kind_type             okind_ff, okind_in;
   logic [7:0]           ochar_ff, ochar_in;
   logic                 olast_ff, olast_in;

   frame_type_type       new_type;
   frame_type_type       eff_type;
   logic                 known_start;
   logic                 is_digit;
   logic [IDX_W-1:0]     ds_cur, de_cur, ds1, de1;
   logic [IDX_W-1:0]     bc_idx;
   logic [CNT_W-1:0]     bc1;
   logic                 wr_cond;
   logic                 ins;
   logic [7:0]           nxt;
   logic                 ok_now;
   logic [DEC_W-1:0]     dec_now;
   logic                 emit;
   logic                 out_free;

   // Frame type implied by the first byte of a frame.
   always_comb begin
      new_type    = type_ff;
      known_start = 1'b0;
      case (byte_ff)
         CH_ACK: begin
            new_type = FT_SOH;
         end
         CH_SOH: begin
            new_type    = FT_SOH;
            known_start = 1'b1;
         end
         CH_STX: begin
            new_type    = FT_STX;
            known_start = 1'b1;
         end
         CH_F: begin
            new_type    = FT_F;
            known_start = 1'b1;
         end
         default: begin
            new_type = type_ff;
         end
      endcase
   end

   assign eff_type = (bc_ff == '0) ? new_type : type_ff;
   assign is_digit = (byte_ff >= CH_ZERO && byte_ff <= CH_NINE) || byte_ff == CH_POINT;
   assign ds_cur   = cmd.first_byte ? '0 : ds_ff;
   assign de_cur   = cmd.first_byte ? '0 : de_ff;
   assign bc_idx   = bc_ff[IDX_W-1:0];
   assign bc1      = bc_ff + CNT_W'(1);
   assign ds1      = (is_digit && ds_cur == '0) ? bc_idx : ds_cur;
   assign de1      = is_digit ? bc_idx : de_cur;
   // Past the digit span only the byte right after it is kept.
   assign wr_cond  = (de_cur == '0) || (bc_ff == CNT_W'(de_cur) + CNT_W'(1));
   assign ins      = (eff_type == FT_F) && (bc1 == POINT_CNT);

   always_comb begin
      bc_in   = bc_ff;
      ds_in   = ds_ff;
      de_in   = de_ff;
      xor_in  = xor_ff;
      type_in = type_ff;
      if (cmd.host_clear) begin
         bc_in = '0;
         ds_in = '0;
         de_in = '0;
      end
      if (cmd.first_byte) begin
         ds_in   = '0;
         de_in   = '0;
         xor_in  = '0;
         type_in = new_type;
      end
      if (cmd.xor_eot) begin
         xor_in = xor_ff ^ CH_ETX;
      end
      if (cmd.xor_byte) begin
         xor_in = xor_ff ^ byte_ff;
      end
      if (cmd.store_byte) begin
         if (ins) begin
            ds_in = (ds1 == '0) ? POINT_IDX : ds1;
            de_in = POINT_IDX;
            bc_in = POINT_CNT + CNT_W'(1);
         end else begin
            ds_in = ds1;
            de_in = de1;
            bc_in = bc1;
         end
      end
      if (cmd.clear_count) begin
         bc_in = '0;
      end
   end

   assign wr_en   = (cmd.store_byte && wr_cond) || cmd.insert_point;
   assign wr_addr = cmd.insert_point ? POINT_IDX : bc_idx;
   assign wr_data = cmd.insert_point ? CH_POINT : byte_ff;

   // The walk looks at the current character and the one after it.
   assign nxt    = (p_ff >= DEPTH_CNT) ? 8'h00 : rdata_ff;
   assign ok_now = ok_ff || cur_ff != CH_ZERO || nxt != CH_ZERO;

   always_comb begin
      dec_now = dec_ff;
      if (ok_now) begin
         if (cur_ff == CH_POINT && dec_ff == '0) begin
            dec_now = DEC_W'(1);
         end else if (dec_ff != '0 && dec_ff <= DEC_LIMIT) begin
            dec_now = dec_ff + DEC_W'(1);
         end
      end
   end

   assign emit     = ok_now && dec_now <= DEC_LIMIT;
   assign out_free = !ov_ff || out_ready;

   always_comb begin
      p_in          = p_ff;
      cur_in        = cur_ff;
      ok_in         = ok_ff;
      dec_in        = dec_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      ov_in         = ov_ff && !out_ready;
      okind_in      = okind_ff;
      ochar_in      = ochar_ff;
      olast_in      = olast_ff;
      if (cmd.walk_init) begin
         p_in          = CNT_W'(ds_ff);
         ok_in         = 1'b0;
         dec_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.walk_prime) begin
         cur_in = rdata_ff;
         p_in   = p_ff + CNT_W'(1);
      end
      if (cmd.walk_adv) begin
         ok_in  = ok_now;
         dec_in = dec_now;
         cur_in = nxt;
         p_in   = p_ff + CNT_W'(1);
         if (emit) begin
            pend_in       = cur_ff;
            pend_valid_in = 1'b1;
            if (pend_valid_ff) begin
               ov_in    = 1'b1;
               okind_in = RK_WEIGHT;
               ochar_in = pend_ff;
               olast_in = 1'b0;
            end
         end
      end
      if (cmd.push_final) begin
         pend_valid_in = 1'b0;
         ov_in         = 1'b1;
         okind_in      = RK_WEIGHT;
         ochar_in      = pend_ff;
         olast_in      = 1'b1;
      end
      if (cmd.push_single) begin
         ov_in    = 1'b1;
         okind_in = cmd.kind;
         ochar_in = 8'h00;
         olast_in = 1'b1;
      end
   end

   assign rd_addr = (p_in >= DEPTH_CNT) ? '0 : p_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= in_action;
         herr_ff   <= in_host_error_active;
         byte_ff   <= in_rx_byte;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      for (int k = 0; k < 3; k++) begin
         if (wr_en && wr_addr == IDX_W'(k)) begin
            hdr_ff[k] <= wr_data;
         end
      end
      rdata_ff <= mem[rd_addr];
      cur_ff   <= cur_in;
      ok_ff    <= ok_in;
      dec_ff   <= dec_in;
      pend_ff  <= pend_in;
      okind_ff <= okind_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
      p_ff     <= p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff         <= '0;
         ds_ff         <= '0;
         de_ff         <= '0;
         xor_ff        <= '0;
         type_ff       <= FT_STX;
         pend_valid_ff <= 1'b0;
         ov_ff         <= 1'b0;
      end else begin
         bc_ff         <= bc_in;
         ds_ff         <= ds_in;
         de_ff         <= de_in;
         xor_ff        <= xor_in;
         type_ff       <= type_in;
         pend_valid_ff <= pend_valid_in;
         ov_ff         <= ov_in;
      end
   end

   always_comb begin
      status.skip        = !scale_enable || herr_ff;
      status.is_req      = action_ff;
      status.bc_zero     = bc_ff == '0;
      status.bc_gt1      = bc_ff > CNT_W'(1);
      status.first_ack   = byte_ff == CH_ACK;
      status.first_start = known_start;
      status.type_soh    = type_ff == FT_SOH;
      status.is_eot      = byte_ff == CH_EOT;
      status.soh_ok      = (xor_ff ^ CH_ETX) == 8'h00 && hdr_ff[2] == CH_STATUS
                           && hdr_ff[0] == CH_SOH && hdr_ff[1] == CH_STX;
      status.insert      = ins;
      status.over_or_lf  = bc_ff >= DEPTH_CNT || byte_ff == CH_LF;
      status.is_cr       = byte_ff == CH_CR;
      status.cr_ok       = (type_ff == FT_STX && hdr_ff[0] == CH_STX)
                           || (type_ff == FT_F && hdr_ff[0] == CH_F);
      status.span_empty  = ds_ff >= de_ff;
      status.out_free    = out_free;
      status.need_push   = emit && pend_valid_ff;
      status.walk_end    = p_ff == CNT_W'(de_ff) + CNT_W'(1);
      status.pend_valid  = pend_valid_ff;
   end

   assign out_valid = ov_ff;
   assign out_kind  = okind_ff;
   assign out_char  = ochar_ff;
   assign out_last  = olast_ff;

endmodule

`default_nettype wire

FILE: sv/swfp_ctrl.sv
// Controller state machine that sequences each word through the datapath.
`default_nettype none

module swfp_ctrl import swfp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = RK_WEIGHT;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.skip) begin
               state_in = ST_IDLE;
            end else if (status.is_req) begin
               cmd.host_clear = 1'b1;
               state_in       = ST_SEND_ENQ;
            end else if (status.bc_zero) begin
               cmd.first_byte = 1'b1;
               if (status.first_ack) begin
                  state_in = ST_SEND_XON;
               end else if (status.first_start) begin
                  cmd.store_byte = 1'b1;
                  state_in       = status.insert ? ST_INSERT : ST_CHECK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (status.type_soh && status.is_eot) begin
               cmd.xor_eot     = 1'b1;
               cmd.clear_count = 1'b1;
               if (!status.soh_ok) begin
                  state_in = ST_SEND_ERR;
               end else if (status.span_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK_PRIME;
               end
            end else begin
               cmd.xor_byte   = status.type_soh && status.bc_gt1;
               cmd.store_byte = 1'b1;
               state_in       = status.insert ? ST_INSERT : ST_CHECK;
            end
         end
         ST_INSERT: begin
            cmd.insert_point = 1'b1;
            state_in         = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.over_or_lf) begin
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.is_cr) begin
               cmd.clear_count = 1'b1;
               if (!status.cr_ok) begin
                  state_in = ST_SEND_ERR;
               end else if (status.span_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK_PRIME;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK_PRIME: begin
            cmd.walk_prime = 1'b1;
            state_in       = ST_WALK_RUN;
         end
         ST_WALK_RUN: begin
            // A character waits while the previous one cannot leave yet.
            if (!status.need_push || status.out_free) begin
               cmd.walk_adv = 1'b1;
               if (status.walk_end) begin
                  state_in = ST_WALK_FLUSH;
               end
            end
         end
         ST_WALK_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.push_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SEND_ENQ: begin
            if (status.out_free) begin
               cmd.push_single = 1'b1;
               cmd.kind        = RK_ENQUIRY;
               state_in        = ST_IDLE;
            end
         end
         ST_SEND_XON: begin
            if (status.out_free) begin
               cmd.push_single = 1'b1;
               cmd.kind        = RK_XON;
               state_in        = ST_IDLE;
            end
         end
         ST_SEND_ERR: begin
            if (status.out_free) begin
               cmd.push_single = 1'b1;
               cmd.kind        = RK_ERROR;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/scale_weight_frame_parser_core.sv
// A byte that completes nothing passes the decide state and, where they apply, the insert and check states.
// A frame end primes the walk, then walks the digit span one stored character a cycle while the
// result side does not stall, and then flushes the last pending character.
// One word is worked on at a time; the last result waits in the output register.
// Reset is synchronous and active high; it clears the frame state and the enable register.
// The frame store is not cleared and needs no clearing pass.
`default_nettype none

module scale_weight_frame_parser_core import swfp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   swfp_req_if.sink                   req_ch,
   swfp_rsp_if.source                 rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic       enable_ff, enable_in;
   logic       reg_hit;
   status_type status;
   cmd_type    cmd;
   kind_type   out_kind;

   assign pready  = 1'b1;
   assign reg_hit = paddr[CSR_ADDR_W-1:2] == REG_SCALE_ENABLE;

   always_comb begin
      enable_in = enable_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign prdata = reg_hit ? {{(CSR_DATA_W-1){1'b0}}, enable_ff} : '0;

   swfp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   swfp_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .scale_enable         (enable_ff),
      .in_action            (req_ch.action),
      .in_rx_byte           (req_ch.rx_byte),
      .in_host_error_active (req_ch.host_error_active),
      .cmd                  (cmd),
      .status               (status),
      .out_ready            (rsp_ch.ready),
      .out_valid            (rsp_ch.valid),
      .out_kind             (out_kind),
      .out_char             (rsp_ch.out_char),
      .out_last             (rsp_ch.last_of_run)
   );

   assign rsp_ch.result_kind = out_kind;

endmodule

`default_nettype wire

FILE: dv/swfp_scoreboard_pkg.sv
// Frame predictor and result scoreboard for the scale weight frame parser testbench.
`timescale 1ns / 100ps

package swfp_scoreboard_pkg;
   import swfp_pkg::*;

   localparam int MAX_RUN      = 32;
   localparam int MAX_DECIMALS = 4;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic       last;
   } weight_word_type;

   class frame_scoreboard;
      bit              scale_on = 1'b0;
      logic [5:0]      count = '0;
      frame_type_type  ftype = FT_STX;
      logic [5:0]      span_lo = '0;
      logic [5:0]      span_hi = '0;
      logic [7:0]      check_xor = '0;
      logic [7:0]      store [BUFFER_DEPTH];
      weight_word_type expected_q[$];
      int              run_base = 0;
      int              errors = 0;

      function int pending();
         return expected_q.size();
      endfunction

      function logic [7:0] peek(int idx);
         return (idx < BUFFER_DEPTH) ? store[idx] : 8'h00;
      endfunction

      function void add_word(kind_type kind, logic [7:0] ch);
         weight_word_type w;
         if (expected_q.size() - run_base >= MAX_RUN) return;
         w.kind = kind;
         w.ch   = (kind == RK_WEIGHT) ? ch : 8'h00;
         w.last = 1'b0;
         expected_q.push_back(w);
      endfunction

      // Walks the digit span, skipping each leading zero that another zero follows, and keeping
      // the point plus at most three decimals.
      function void walk_span();
         int         i;
         int         dec;
         bit         lead_done;
         logic [7:0] ch;
         count = '0;
         if (span_lo >= span_hi) return;
         dec = 0;
         lead_done = 1'b0;
         for (i = span_lo; i <= span_hi && i < BUFFER_DEPTH; i++) begin
            if (!lead_done)
               lead_done = (peek(i) != CH_ZERO) || (peek(i + 1) != CH_ZERO);
            if (lead_done) begin
               ch = peek(i);
               if (ch == CH_POINT && dec == 0)
                  dec = 1;
               else if (dec != 0)
                  dec++;
               if (dec <= MAX_DECIMALS) add_word(RK_WEIGHT, ch);
            end
         end
      endfunction

      function void parse_byte(logic [7:0] c);
         if (count == 0) begin
            span_lo = '0;
            span_hi = '0;
            check_xor = '0;
            if (c == CH_ACK) begin
               ftype = FT_SOH;
               add_word(RK_XON, 8'h00);
               return;
            end else if (c == CH_SOH) begin
               ftype = FT_SOH;
            end else if (c == CH_STX) begin
               ftype = FT_STX;
            end else if (c == CH_F) begin
               ftype = FT_F;
            end else begin
               return;
            end
         end else if (ftype == FT_SOH) begin
            if (c == CH_EOT) begin
               check_xor ^= CH_ETX;
               if (check_xor != 8'h00 || peek(2) != CH_STATUS || peek(0) != CH_SOH ||
                   peek(1) != CH_STX) begin
                  count = '0;
                  add_word(RK_ERROR, 8'h00);
               end else begin
                  walk_span();
               end
               return;
            end
            if (count > 1) check_xor ^= c;
         end

         // Once a digit span exists, only the byte right after it is still stored.
         if (span_hi == 0 || (count >= span_hi && count - span_hi <= 1))
            if (count < BUFFER_DEPTH) store[count] = c;

         if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT) begin
            if (span_lo == 0) span_lo = count;
            span_hi = count;
         end
         count++;

         if (ftype == FT_F && count == FIXED_POINT_COLUMN) begin
            if (span_lo == 0) span_lo = count;
            span_hi = count;
            store[count] = CH_POINT;
            count++;
         end

         if (count >= BUFFER_DEPTH || c == CH_LF) begin
            count = '0;
            return;
         end
         if (c == CH_CR) begin
            if ((ftype == FT_STX && peek(0) == CH_STX) || (ftype == FT_F && peek(0) == CH_F)) begin
               walk_span();
            end else begin
               count = '0;
               add_word(RK_ERROR, 8'h00);
            end
         end
      endfunction

      function void note_word(logic act, logic [7:0] c, logic herr);
         if (!scale_on || herr) return;
         run_base = expected_q.size();
         if (act) begin
            count = '0;
            span_lo = '0;
            span_hi = '0;
            add_word(RK_ENQUIRY, 8'h00);
         end else begin
            parse_byte(c);
         end
         if (expected_q.size() > run_base) expected_q[expected_q.size() - 1].last = 1'b1;
      endfunction

      function void check_word(logic [1:0] kind, logic [7:0] ch, logic last);
         weight_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected word: kind %0d char %02h last %0b", kind, ch, last);
            return;
         end
         want = expected_q.pop_front();
         if (want.kind !== kind || want.ch !== ch || want.last !== last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("word differs: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
                        want.kind, want.ch, want.last, kind, ch, last);
         end
      endfunction
   endclass

endpackage

FILE: dv/scale_weight_frame_parser_core_tb.sv
// Testbench top for the scale weight frame parser core: stimulus, idling and final verdict.
`timescale 1ns / 100ps

module scale_weight_frame_parser_core_tb;
   import swfp_pkg::*;
   import swfp_scoreboard_pkg::*;

   localparam int     RANDOM_WORDS  = 220;
   localparam int     CALM_WORDS    = 60;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     HOLD_CYCLES   = 400;
   localparam longint LIMIT_NS      = 15_000_000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   swfp_req_if req_ch();
   swfp_rsp_if rsp_ch();

   frame_scoreboard board;
   bit              idle_on;
   bit              hold_req;
   bit              scale_on;
   int              fed_words;
   logic [7:0]      frame_q[$];

   scale_weight_frame_parser_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
         board.check_word(rsp_ch.result_kind, rsp_ch.out_char, rsp_ch.last_of_run);
   end

   // Result side: short random stalls, and one long hold-off so the block backs up.
   initial begin : result_sink
      int held;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-3:0] index, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      scale_on = data[0];
      board.scale_on = data[0];
   endtask

   task automatic send_word(input logic act, input logic [7:0] b, input logic herr);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.action            <= act;
      req_ch.rx_byte           <= b;
      req_ch.host_error_active <= herr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_word(act, b, herr);
      if (scale_on && !herr) fed_words++;
   endtask

   task automatic send_frame(input bit noisy);
      foreach (frame_q[i]) begin
         if (noisy && $urandom_range(0, 24) == 0)
            send_word(1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
         send_word(1'b0, frame_q[i], 1'b0);
      end
      frame_q.delete();
   endtask

   // Waits for the last expected word, then lets any word without results drain.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] any_digit();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] filler();
      return ($urandom_range(0, 3) == 0) ? 8'h20 : 8'(8'h41 + $urandom_range(0, 25));
   endfunction

   function automatic void put_weight();
      int whole;
      repeat ($urandom_range(0, 4)) frame_q.push_back(CH_ZERO);
      whole = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 5);
      repeat (whole) frame_q.push_back(any_digit());
      if ($urandom_range(0, 2) != 0) begin
         frame_q.push_back(CH_POINT);
         repeat ($urandom_range(0, 5)) frame_q.push_back(any_digit());
      end
   endfunction

   function automatic void build_stx();
      frame_q.push_back(CH_STX);
      repeat ($urandom_range(0, 3)) frame_q.push_back(filler());
      if ($urandom_range(0, 15) == 0)
         repeat ($urandom_range(15, 30)) frame_q.push_back(filler());
      put_weight();
      if ($urandom_range(0, 1) == 1) frame_q.push_back("k");
      if ($urandom_range(0, 7) == 0) frame_q.push_back(8'($urandom));
      frame_q.push_back(CH_CR);
   endfunction

   function automatic void build_f();
      frame_q.push_back(CH_F);
      repeat ($urandom_range(0, 5)) frame_q.push_back(8'h20);
      put_weight();
      if ($urandom_range(0, 7) == 0) frame_q.push_back(8'($urandom));
      frame_q.push_back(CH_CR);
   endfunction

   // Check byte makes the XOR from the status byte through the check byte, with ETX, zero, unless mode 0 breaks it.
   function automatic void build_soh(input bit broken);
      int         mode;
      int         i;
      logic [7:0] sum;
      frame_q.push_back(CH_SOH);
      frame_q.push_back(CH_STX);
      frame_q.push_back(CH_STATUS);
      frame_q.push_back(filler());
      put_weight();
      mode = broken ? $urandom_range(0, 2) : 3;
      if (mode == 1) frame_q[2] = 8'($urandom_range(0, 255));
      if (mode == 2) frame_q[1] = 8'($urandom_range(0, 255));
      sum = CH_ETX;
      for (i = 2; i < frame_q.size(); i++) sum ^= frame_q[i];
      if (mode == 0) sum ^= 8'($urandom_range(1, 255));
      frame_q.push_back(sum);
      frame_q.push_back(CH_EOT);
   endfunction

   task automatic send_broken();
      int cut;
      int tail;
      case ($urandom_range(0, 2))
         0: build_stx();
         1: build_f();
         default: build_soh(1'b0);
      endcase
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      tail = $urandom_range(0, 2);
      if (tail == 0) frame_q.push_back(CH_LF);
      send_frame(1'b1);
      if (tail == 1) send_word(1'b1, 8'($urandom), 1'b0);
   endtask

   task automatic run_directed();
      // A letter frame runs over the buffer, is dropped, and leaves every store entry written.
      frame_q.push_back(CH_STX);
      repeat (BUFFER_DEPTH - 1) frame_q.push_back("A");
      send_frame(1'b0);
      send_word(1'b1, 8'hFF, 1'b0);
      send_word(1'b0, CH_ACK, 1'b1);
      send_word(1'b0, CH_ACK, 1'b0);
      send_word(1'b0, 8'hFF, 1'b0);
      frame_q = {CH_STX, CH_ZERO, CH_ZERO, "1", CH_POINT, "2", "3", "4", "5", CH_CR};
      send_frame(1'b0);
      frame_q = {CH_F, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, "1", "2", "3", "4", "5", CH_CR};
      send_frame(1'b0);
      frame_q = {CH_SOH, CH_STX, CH_STATUS, "7", "5", 8'(CH_STATUS ^ "7" ^ "5" ^ CH_ETX), CH_EOT};
      send_frame(1'b0);
      frame_q = {CH_SOH, CH_CR};
      send_frame(1'b0);
      frame_q = {CH_STX, CH_LF};
      send_frame(1'b0);
      frame_q = {CH_STX, CH_CR};
      send_frame(1'b0);
   endtask

   task automatic run_random(input int target);
      int pick;
      while (fed_words < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            build_stx();
            send_frame(1'b1);
         end else if (pick < 46) begin
            build_f();
            send_frame(1'b1);
         end else if (pick < 66) begin
            build_soh(1'b0);
            send_frame(1'b1);
         end else if (pick < 74) begin
            build_soh(1'b1);
            send_frame(1'b1);
         end else if (pick < 79) begin
            send_word(1'b0, CH_ACK, 1'b0);
         end else if (pick < 84) begin
            send_word(1'b1, 8'($urandom), 1'b0);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 4)) send_word(1'b0, 8'($urandom), 1'b0);
         end else begin
            send_broken();
         end
      end
   endtask

   initial begin : stimulus
      board     = new();
      idle_on   = 1'b1;
      hold_req  = 1'b0;
      scale_on  = 1'b0;
      fed_words = 0;
      reset                    <= 1'b1;
      req_ch.valid             <= 1'b0;
      req_ch.action            <= 1'b0;
      req_ch.rx_byte           <= 8'h00;
      req_ch.host_error_active <= 1'b0;
      psel                     <= 1'b0;
      penable                  <= 1'b0;
      pwrite                   <= 1'b0;
      paddr                    <= '0;
      pwdata                   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_SCALE_ENABLE, 0);
      repeat (2) send_word(1'b0, CH_STX, 1'b0);
      settle();
      write_reg(REG_SCALE_ENABLE, 1);
      run_directed();

      fed_words = 0;
      hold_req = 1'b1;
      run_random(RANDOM_WORDS / 2);
      settle();

      // With the port off every word is dropped, whatever it holds.
      write_reg(REG_SCALE_ENABLE, 0);
      repeat (12) send_word(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
      settle();
      write_reg(REG_SCALE_ENABLE, 1);

      run_random(RANDOM_WORDS - CALM_WORDS);
      idle_on = 1'b0;
      run_random(RANDOM_WORDS);
      settle();

      if (board.errors == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
